### design/dot_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dot_pkg
// Shared types and constants of the dual output thermostat.
// ----------------------------------------------------------------------------
package dot_pkg;

  localparam int SAMPLE_W      = 14;  // width of the sample field on the port
  localparam int SAMPLE_BITS_D = 14;  // default number of sample bits used
  localparam int VALUE_BITS    = 14;  // threshold and limit value width
  localparam int WORD_BITS     = 15;  // threshold / limit word width
  localparam int FORCE_POS     = 14;  // polarity / forced result bit
  localparam int HOLD_BITS     = 16;
  localparam int TIME_BITS     = 32;
  localparam int CFG_DATA_BITS = 16;
  localparam int REG_IDX_BITS  = 3;

  localparam logic [REG_IDX_BITS-1:0] REG_HEATER_THR = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_FAN_THR    = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_HEATER_LO  = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_HEATER_HI  = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_FAN_LO     = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_FAN_HI     = 3'd5;
  localparam logic [REG_IDX_BITS-1:0] REG_DWELL      = 3'd6;

  localparam logic [WORD_BITS-1:0] LIMIT_LO_RESET = 15'h0000;
  localparam logic [WORD_BITS-1:0] LIMIT_HI_RESET = 15'h3fff;

  typedef struct packed {
    logic [WORD_BITS-1:0] heater_thr;
    logic [WORD_BITS-1:0] fan_thr;
    logic [WORD_BITS-1:0] heater_lo;
    logic [WORD_BITS-1:0] heater_hi;
    logic [WORD_BITS-1:0] fan_lo;
    logic [WORD_BITS-1:0] fan_hi;
    logic [HOLD_BITS-1:0] dwell_ms;
  } dot_cfg_t;

  typedef struct packed {
    logic heater_on;
    logic fan_on;
    logic heater_switched;
    logic fan_switched;
    logic holding;
  } dot_result_t;

endpackage
`default_nettype wire

### design/dot_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dot_in_if
// Sample channel: valid/ready handshake with sample and timestamp.
// ----------------------------------------------------------------------------
interface dot_in_if;
  import dot_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [SAMPLE_W-1:0]  sample;
  logic [TIME_BITS-1:0] now_ms;

  modport source (output valid, output sample, output now_ms, input ready);
  modport sink   (input valid, input sample, input now_ms, output ready);
endinterface
`default_nettype wire

### design/dot_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dot_out_if
// Result channel: valid/ready handshake with the two output levels and flags.
// ----------------------------------------------------------------------------
interface dot_out_if;
  logic valid;
  logic ready;
  logic heater_on;
  logic fan_on;
  logic heater_switched;
  logic fan_switched;
  logic holding;

  modport source (output valid, output heater_on, output fan_on,
                  output heater_switched, output fan_switched, output holding,
                  input ready);
  modport sink   (input valid, input heater_on, input fan_on,
                  input heater_switched, input fan_switched, input holding,
                  output ready);
endinterface
`default_nettype wire

### design/dot_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dot_cfg_regs
// Configuration register file, written by index; writes beyond the list drop.
// ----------------------------------------------------------------------------
module dot_cfg_regs (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 write_en,
  input  wire logic [dot_pkg::REG_IDX_BITS-1:0]     reg_index,
  input  wire logic [dot_pkg::CFG_DATA_BITS-1:0]    write_data,
  output dot_pkg::dot_cfg_t                         cfg
);
  import dot_pkg::*;

  dot_cfg_t regs;

  assign cfg = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.heater_thr <= '0;
      regs.fan_thr    <= '0;
      regs.heater_lo  <= LIMIT_LO_RESET;
      regs.heater_hi  <= LIMIT_HI_RESET;
      regs.fan_lo     <= LIMIT_LO_RESET;
      regs.fan_hi     <= LIMIT_HI_RESET;
      regs.dwell_ms   <= '0;
    end else if (write_en) begin
      case (reg_index)
        REG_HEATER_THR: regs.heater_thr <= write_data[WORD_BITS-1:0];
        REG_FAN_THR:    regs.fan_thr    <= write_data[WORD_BITS-1:0];
        REG_HEATER_LO:  regs.heater_lo  <= write_data[WORD_BITS-1:0];
        REG_HEATER_HI:  regs.heater_hi  <= write_data[WORD_BITS-1:0];
        REG_FAN_LO:     regs.fan_lo     <= write_data[WORD_BITS-1:0];
        REG_FAN_HI:     regs.fan_hi     <= write_data[WORD_BITS-1:0];
        REG_DWELL:      regs.dwell_ms   <= write_data[HOLD_BITS-1:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end
endmodule
`default_nettype wire

### design/dot_level.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dot_level
// Wanted level of one output: threshold compare with forcing limits.
// ----------------------------------------------------------------------------
module dot_level #(
  parameter int SAMPLE_BITS = dot_pkg::SAMPLE_BITS_D
) (
  input  wire logic [SAMPLE_BITS-1:0]        sample,
  input  wire logic [dot_pkg::WORD_BITS-1:0] thr_word,
  input  wire logic [dot_pkg::WORD_BITS-1:0] lo_word,
  input  wire logic [dot_pkg::WORD_BITS-1:0] hi_word,
  output logic                               wanted
);
  import dot_pkg::*;

  logic [VALUE_BITS-1:0] s_ext;
  logic                  at_or_above;

  assign s_ext = VALUE_BITS'(sample);

  always_comb begin
    if (s_ext < lo_word[VALUE_BITS-1:0]) begin
      at_or_above = lo_word[FORCE_POS];
    end else if (s_ext >= hi_word[VALUE_BITS-1:0]) begin
      at_or_above = hi_word[FORCE_POS];
    end else begin
      at_or_above = (s_ext >= thr_word[VALUE_BITS-1:0]);
    end
  end

  // polarity bit set: on below the threshold
  assign wanted = at_or_above ^ thr_word[FORCE_POS];
endmodule
`default_nettype wire

### design/dot_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dot_core
// Hold check, output states, result register: one sample a cycle unless stalled.
// ----------------------------------------------------------------------------
module dot_core #(
  parameter int SAMPLE_BITS = dot_pkg::SAMPLE_BITS_D
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire dot_pkg::dot_cfg_t                   cfg,
  input  wire logic                                item_valid,
  input  wire logic [SAMPLE_BITS-1:0]              sample,
  input  wire logic [dot_pkg::TIME_BITS-1:0]       now_ms,
  input  wire logic                                res_ready,
  output logic                                     res_valid,
  output dot_pkg::dot_result_t                     res,
  output logic                                     advance
);
  import dot_pkg::*;

  logic                 heater_state;
  logic                 fan_state;
  logic [TIME_BITS-1:0] last_switch_time;

  logic [TIME_BITS-1:0] elapsed;
  logic                 hold_now;
  logic                 heater_want;
  logic                 fan_want;
  logic                 heater_sw;
  logic                 fan_sw;
  logic                 take;

  dot_level #(.SAMPLE_BITS(SAMPLE_BITS)) u_heater_level (
    .sample   (sample),
    .thr_word (cfg.heater_thr),
    .lo_word  (cfg.heater_lo),
    .hi_word  (cfg.heater_hi),
    .wanted   (heater_want)
  );

  dot_level #(.SAMPLE_BITS(SAMPLE_BITS)) u_fan_level (
    .sample   (sample),
    .thr_word (cfg.fan_thr),
    .lo_word  (cfg.fan_lo),
    .hi_word  (cfg.fan_hi),
    .wanted   (fan_want)
  );

  // wrap-safe elapsed time since the last switch
  assign elapsed   = now_ms - last_switch_time;
  assign hold_now  = elapsed < TIME_BITS'(cfg.dwell_ms);
  assign heater_sw = !hold_now && (heater_want != heater_state);
  assign fan_sw    = !hold_now && (fan_want != fan_state);

  assign advance = !res_valid || res_ready;
  assign take    = advance && item_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid        <= 1'b0;
      heater_state     <= 1'b0;
      fan_state        <= 1'b0;
      last_switch_time <= '0;
    end else begin
      if (advance) begin
        res_valid <= item_valid;
      end
      if (take) begin
        if (heater_sw) begin
          heater_state <= heater_want;
        end
        if (fan_sw) begin
          fan_state <= fan_want;
        end
        if (heater_sw || fan_sw) begin
          last_switch_time <= now_ms;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res.heater_on       <= heater_sw ? heater_want : heater_state;
      res.fan_on          <= fan_sw ? fan_want : fan_state;
      res.heater_switched <= heater_sw;
      res.fan_switched    <= fan_sw;
      res.holding         <= hold_now;
    end
  end
endmodule
`default_nettype wire

### design/dual_output_thermostat_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dual_output_thermostat_unit
// Bang-bang heater and fan control with a shared minimum hold time.
// ----------------------------------------------------------------------------
// Each word on in_ch carries one converter sample and a millisecond timestamp;
// the block returns exactly one word on out_ch per sample, in order, giving the
// heater and fan levels after that sample, which of them switched, and whether
// the hold time blocked evaluation. A sample passes from acceptance through the
// input register, then the result register, to its result word, and the block
// accepts one sample every cycle unless out_ch stalls: the heater, fan and
// last-switch-time state update in the same cycle the result is registered, so
// the next sample sees it at once. The result register separates the two
// sides, so a new sample is still taken while a finished result waits;
// in_ch.ready drops only when both registers are full and out_ch is stalled.
// Configuration is written through write_en / reg_index / write_data (0 heater
// threshold, 1 fan threshold, 2..5 heater and fan low/high limits, 6 hold time)
// while no sample is in flight, a user duty the block does not enforce. A write
// to index 7 is dropped. Only the low SAMPLE_BITS bits of the sample are used.
// ----------------------------------------------------------------------------
module dual_output_thermostat_unit #(
  parameter int SAMPLE_BITS = dot_pkg::SAMPLE_BITS_D
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  dot_in_if.sink                                 in_ch,
  dot_out_if.source                              out_ch,
  input  wire logic                              write_en,
  input  wire logic [dot_pkg::REG_IDX_BITS-1:0]  reg_index,
  input  wire logic [dot_pkg::CFG_DATA_BITS-1:0] write_data
);
  import dot_pkg::*;

  dot_cfg_t             cfg;
  dot_result_t          res;
  logic                 res_valid;
  logic                 advance;

  // input register
  logic                   item_valid;
  logic [SAMPLE_BITS-1:0] item_sample;
  logic [TIME_BITS-1:0]   item_now;
  logic                   in_take;

  dot_cfg_regs u_cfg (
    .clk        (clk),
    .rst        (rst),
    .write_en   (write_en),
    .reg_index  (reg_index),
    .write_data (write_data),
    .cfg        (cfg)
  );

  // The input register empties whenever the core moves its word on, so it can
  // refill in the same cycle.
  assign in_ch.ready = !item_valid || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ch.ready) begin
      item_valid <= in_ch.valid;
    end
  end

  // payload: hold until the next accepted word, keep only the used bits
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_sample <= in_ch.sample[SAMPLE_BITS-1:0];
      item_now    <= in_ch.now_ms;
    end
  end

  dot_core #(.SAMPLE_BITS(SAMPLE_BITS)) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .sample     (item_sample),
    .now_ms     (item_now),
    .res_ready  (out_ch.ready),
    .res_valid  (res_valid),
    .res        (res),
    .advance    (advance)
  );

  // drive the result channel straight from the result register
  assign out_ch.valid           = res_valid;
  assign out_ch.heater_on       = res.heater_on;
  assign out_ch.fan_on          = res.fan_on;
  assign out_ch.heater_switched = res.heater_switched;
  assign out_ch.fan_switched    = res.fan_switched;
  assign out_ch.holding         = res.holding;
endmodule
`default_nettype wire

### design/dot_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dot_checker
// Port-level checks of the thermostat, bound to the top level.
// ----------------------------------------------------------------------------
module dot_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic heater_on,
  input wire logic fan_on,
  input wire logic heater_switched,
  input wire logic fan_switched,
  input wire logic holding
);
  logic out_take;
  logic last_heater;
  logic last_fan;

  assign out_take = out_valid && out_ready;

  // levels last delivered; both start off
  always_ff @(posedge clk) begin
    if (rst) begin
      last_heater <= 1'b0;
      last_fan    <= 1'b0;
    end else if (out_take) begin
      last_heater <= heater_on;
      last_fan    <= fan_on;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(heater_on) && $stable(fan_on)
      && $stable(holding))
    else $error("result word changed while stalled");

  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without an output stall");

  a_hold_no_switch: assert property (@(posedge clk) disable iff (rst)
    out_take && holding |-> !heater_switched && !fan_switched)
    else $error("output switched during hold time");

  a_heater_track: assert property (@(posedge clk) disable iff (rst)
    out_take |-> (heater_on != last_heater) == heater_switched)
    else $error("heater level and switch flag disagree");

  a_fan_track: assert property (@(posedge clk) disable iff (rst)
    out_take |-> (fan_on != last_fan) == fan_switched)
    else $error("fan level and switch flag disagree");
endmodule

bind dual_output_thermostat_unit dot_checker u_dot_checker (
  .clk             (clk),
  .rst             (rst),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .heater_on       (out_ch.heater_on),
  .fan_on          (out_ch.fan_on),
  .heater_switched (out_ch.heater_switched),
  .fan_switched    (out_ch.fan_switched),
  .holding         (out_ch.holding)
);
`default_nettype wire
